/* sv/hlg_pkg.sv */
// Shared types and constants for the Huber loss with gradient core.
package hlg_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DeltaW = 31;
  localparam int unsigned AccW   = 64;
  localparam int unsigned RowsW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DELTA = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROWS  = 2'd2;

  localparam logic [1:0] RED_SUM  = 2'd0;
  localparam logic [1:0] RED_MEAN = 2'd1;
  localparam logic [1:0] RED_ROWS = 2'd2;

  localparam logic [DeltaW-1:0] DELTA_RESET = 31'd65536;
  localparam logic [1:0]        MODE_RESET  = RED_MEAN;
  localparam logic [RowsW-1:0]  ROWS_RESET  = 16'd1;

  localparam int unsigned TermShift = 17;

  typedef struct packed {
    logic load_in;
    logic cmp;
    logic mul_a;
    logic mul_b;
    logic term;
    logic acc;
    logic div_start;
    logic out_load;
  } hlg_cmd_t;

  typedef struct packed {
    logic clip;
    logic last;
    logic div_done;
    logic out_free;
  } hlg_sts_t;

endpackage

/* sv/hlg_div.sv */
// Restoring divider, one quotient bit per cycle.
module hlg_div
  import hlg_pkg::*;
#(
  parameter int unsigned DividendW = 64,
  parameter int unsigned DivisorW  = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 done,
  output logic [DividendW-1:0] quotient
);

  localparam int unsigned StepW = $clog2(DividendW);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [StepW-1:0]     step_r, step_nxt;
  logic [DivisorW-1:0]  rem_r, rem_nxt;
  logic [DividendW-1:0] quo_r, quo_nxt;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    trial_sub;
  logic                 fits;

  always_comb begin
    trial     = {rem_r, quo_r[DividendW-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial_sub[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_nxt  = {quo_r[DividendW-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(DividendW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/hlg_dp.sv */
// Datapath: configuration registers, residual, shared multiplier, accumulator, divider and output word.
module hlg_dp
  import hlg_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        in_tdata,
  input  logic               in_tlast,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  hlg_cmd_t           cmd,
  output hlg_sts_t           sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DivW = (CntW > RowsW) ? CntW : RowsW;

  logic [DeltaW-1:0]       delta_r;
  logic [1:0]              mode_r;
  logic [RowsW-1:0]        rows_r;

  logic signed [DataW-1:0] diff_r, diff_nxt;
  logic [DataW-1:0]        mag_r, mag_nxt;
  logic                    last_r;
  logic                    clip_r;
  logic [DataW-1:0]        grad_r;
  logic [AccW-1:0]         prod_r;
  logic [AccW-1:0]         sq_r;
  logic [AccW-1:0]         term_r;
  logic [AccW-1:0]         acc_r;
  logic [CntW-1:0]         cnt_r;
  logic                    sat_r;

  logic                    out_valid_r;
  logic [DataW-1:0]        out_grad_r;
  logic [DeltaW-1:0]       out_loss_r;
  logic                    out_last_r;
  logic                    out_flag_r;

  logic [DataW:0]          diff_wide;
  logic                    diff_hi, diff_lo;
  logic [DataW-1:0]        delta_ext;
  logic [DataW-1:0]        mul_x, mul_y;
  logic [AccW-1:0]         mul_p;
  logic [AccW-1:0]         lin_tmp;
  logic [AccW:0]           acc_sum;
  logic [DivW-1:0]         div_sel, divisor;
  logic                    div_done;
  logic [AccW-1:0]         quotient;
  logic                    loss_sat;
  logic [DeltaW-1:0]       loss_val;

  assign delta_ext = {1'b0, delta_r};

  always_comb begin
    diff_wide = {in_tdata[31], in_tdata[31:0]} - {in_tdata[63], in_tdata[63:32]};
    diff_hi   = !diff_wide[DataW] && diff_wide[DataW-1];
    diff_lo   = diff_wide[DataW] && !diff_wide[DataW-1];
    if (diff_hi) begin
      diff_nxt = {1'b0, {(DataW-1){1'b1}}};
    end else if (diff_lo) begin
      diff_nxt = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      diff_nxt = diff_wide[DataW-1:0];
    end
    mag_nxt = diff_nxt[DataW-1] ? (~diff_nxt + 1'b1) : diff_nxt;
  end

  always_comb begin
    mul_x = mag_r;
    mul_y = clip_r ? delta_ext : mag_r;
    if (cmd.mul_b) begin
      mul_x = delta_ext;
      mul_y = delta_ext;
    end
    mul_p = {32'b0, mul_x} * {32'b0, mul_y};
  end

  assign lin_tmp = {prod_r[AccW-2:0], 1'b0} - sq_r;
  assign acc_sum = {1'b0, acc_r} + {1'b0, term_r};

  always_comb begin
    case (mode_r)
      RED_MEAN: div_sel = DivW'(cnt_r);
      RED_ROWS: div_sel = DivW'(rows_r);
      default:  div_sel = DivW'(1);
    endcase
    divisor = (div_sel == '0) ? DivW'(1) : div_sel;
  end

  hlg_div #(
    .DividendW(AccW),
    .DivisorW (DivW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(acc_r),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quotient)
  );

  assign loss_sat = last_r && (quotient[AccW-1:DeltaW] != '0);
  assign loss_val = !last_r ? '0 : (loss_sat ? '1 : quotient[DeltaW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RESET;
      mode_r  <= MODE_RESET;
      rows_r  <= ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELTA: delta_r <= cfg_data[DeltaW-1:0];
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_ROWS:  rows_r  <= cfg_data[RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      diff_r <= diff_nxt;
      mag_r  <= mag_nxt;
      last_r <= in_tlast;
    end
    if (cmd.cmp) begin
      clip_r <= mag_r > delta_ext;
      if (mag_r > delta_ext) begin
        grad_r <= diff_r[DataW-1] ? (~delta_ext + 1'b1) : delta_ext;
      end else begin
        grad_r <= diff_r;
      end
    end
    if (cmd.mul_a) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_b) begin
      sq_r <= mul_p;
    end
    if (cmd.term) begin
      term_r <= clip_r ? {{TermShift{1'b0}}, lin_tmp[AccW-1:TermShift]}
                       : {{TermShift{1'b0}}, prod_r[AccW-1:TermShift]};
    end
    if (cmd.out_load) begin
      out_grad_r <= grad_r;
      out_loss_r <= loss_val;
      out_last_r <= last_r;
      out_flag_r <= sat_r | loss_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in && (diff_hi || diff_lo)) begin
        sat_r <= 1'b1;
      end
      if (cmd.acc) begin
        if (acc_sum[AccW]) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[AccW-1:0];
        end
        if (cnt_r < CntW'(MAX_ITEMS)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.out_load && last_r) begin
        acc_r <= '0;
        cnt_r <= '0;
        sat_r <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clip     = clip_r;
    sts.last     = last_r;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_loss_r, out_grad_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flag_r;

endmodule

/* sv/hlg_ctrl.sv */
// Controller state machine sequencing one word through the datapath.
module hlg_ctrl
  import hlg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  hlg_sts_t sts,
  output hlg_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CMP  = 9'b000000010,
    S_MULA = 9'b000000100,
    S_MULB = 9'b000001000,
    S_TERM = 9'b000010000,
    S_ACC  = 9'b000100000,
    S_DST  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = sts.clip ? S_MULB : S_TERM;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.term  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_DST : S_OUT;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/huber_loss_with_gradient_core.sv */
// Top level of the Huber loss with gradient core; one word is in flight at a time.
// An accepted word steps through compare, multiply, term, accumulate and output load, with a
// second multiply if clipped; a last word also runs the 64-step divider for the reduction.
// No new word is taken until the previous result is loaded, which waits for output room.
// Synchronous active-low reset restores the register defaults and clears the accumulator,
// the item count, the saturation flag and all handshake state.
module huber_loss_with_gradient_core
  import hlg_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,   // pred_value, target_value
  input  logic               in_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,  // residual_grad, loss_value, zero pad
  output logic               out_tlast,
  output logic               out_tuser   // overflow_flag
);

  hlg_cmd_t cmd;
  hlg_sts_t sts;

  assign cfg_ready = 1'b1;

  hlg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlg_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

/* tb/huber_loss_with_gradient_core_test.sv */
// Self-checking stream testbench for the Huber loss with gradient core.
module huber_loss_with_gradient_core_test;
  import hlg_pkg::*;

  localparam int unsigned MaxItems      = 1048576;
  localparam int unsigned RandomWords   = 450;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 100;
  localparam logic [1:0]  RED_SUM_ALIAS = 2'd3;
  localparam longint      DiffMax       = 64'sd2147483647;
  localparam longint      DiffMin       = -64'sd2147483648;

  typedef struct {
    logic [31:0] grad;
    logic [30:0] loss;
    logic        loss_valid;
    logic        overflow;
  } huber_result_t;

  class huber_tracker;
    logic [DeltaW-1:0] delta;
    logic [1:0]        mode;
    logic [RowsW-1:0]  rows;
    logic [AccW-1:0]   acc;
    logic [20:0]       count;
    bit                sat;
    huber_result_t     pending_results[$];
    int unsigned       errors;

    function new();
      delta  = DELTA_RESET;
      mode   = MODE_RESET;
      rows   = ROWS_RESET;
      acc    = '0;
      count  = '0;
      sat    = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_DELTA: delta = data[DeltaW-1:0];
        CFG_MODE:  mode  = data[1:0];
        CFG_ROWS:  rows  = data[RowsW-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(input logic [31:0] p, input logic [31:0] t, input logic last);
      longint        diff;
      logic [63:0]   mag;
      logic [63:0]   wide_delta;
      logic [63:0]   term;
      logic [64:0]   sum;
      logic [63:0]   divisor;
      logic [63:0]   loss;
      huber_result_t r;
      diff = longint'(signed'(p)) - longint'(signed'(t));
      if (diff > DiffMax) begin
        diff = DiffMax;
        sat  = 1'b1;
      end
      if (diff < DiffMin) begin
        diff = DiffMin;
        sat  = 1'b1;
      end
      mag        = (diff < 0) ? -diff : diff;
      wide_delta = {33'b0, delta};
      if (mag <= wide_delta) begin
        r.grad = diff[31:0];
        term   = (mag * mag) >> TermShift;
      end else begin
        r.grad = (diff > 0) ? {1'b0, delta} : -{1'b0, delta};
        term   = (((wide_delta << 1) * mag) - (wide_delta * wide_delta)) >> TermShift;
      end
      sum = {1'b0, acc} + {1'b0, term};
      if (sum[64]) begin
        acc = '1;
        sat = 1'b1;
      end else begin
        acc = sum[63:0];
      end
      if (count < MaxItems) count = count + 1'b1;
      loss = '0;
      if (last) begin
        if (mode == RED_MEAN) divisor = {43'b0, count};
        else if (mode == RED_ROWS) divisor = {48'b0, rows};
        else divisor = 64'd1;
        if (divisor == 0) divisor = 64'd1;
        loss = acc / divisor;
        if (loss > 64'h7FFF_FFFF) begin
          loss = 64'h7FFF_FFFF;
          sat  = 1'b1;
        end
      end
      r.loss       = loss[30:0];
      r.loss_valid = last;
      r.overflow   = sat;
      pending_results.push_back(r);
      if (last) begin
        acc   = '0;
        count = '0;
        sat   = 1'b0;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_word(input logic [63:0] data, input logic last, input logic user);
      huber_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word %h arrived with nothing pending", data));
        return;
      end
      want = pending_results.pop_front();
      if (data[31:0] !== want.grad)
        report($sformatf("residual %h, wanted %h", data[31:0], want.grad));
      if (data[62:32] !== want.loss)
        report($sformatf("loss %h, wanted %h", data[62:32], want.loss));
      if (data[63] !== 1'b0)
        report("padding bit of the result word is not zero");
      if (last !== want.loss_valid)
        report($sformatf("loss valid %b, wanted %b", last, want.loss_valid));
      if (user !== want.overflow)
        report($sformatf("overflow %b, wanted %b", user, want.overflow));
    endtask
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [31:0]        cfg_data   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [63:0]        out_tdata;
  logic               out_tlast;
  logic               out_tuser;

  bit                 calm = 1'b0;
  int unsigned        quiet_cycles = 0;
  huber_tracker       board = new();

  huber_loss_with_gradient_core #(
    .MAX_ITEMS(MaxItems)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_word(out_tdata, out_tlast, out_tuser);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [31:0] p, input logic [31:0] t, input logic last);
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, p};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    board.note_word(p, t, last);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_target(input logic [31:0] p);
    longint      lim;
    logic [31:0] off;
    if ($urandom_range(3) == 0) return rand_value();
    lim = 2 * longint'(board.delta) + 2;
    if (lim > 64'sh0000_0000_FFFF_FFFF) lim = 64'sh0000_0000_FFFF_FFFF;
    off = $urandom_range(0, lim[31:0]) - lim[32:1];
    return p - off;
  endfunction

  task automatic rand_config();
    logic [31:0] value;
    case ($urandom_range(5))
      0: value = 32'd0;
      1: value = 32'h7FFF_FFFF;
      2, 3: value = $urandom_range(0, 32'h0003_0000);
      default: value = $urandom();
    endcase
    value[31] = 1'($urandom_range(1));
    write_reg(CFG_DELTA, value);
    value = $urandom();
    value[1:0] = 2'($urandom_range(3));
    write_reg(CFG_MODE, value);
    case ($urandom_range(5))
      0: value = 32'd0;
      1: value = 32'd65535;
      2, 3: value = $urandom_range(1, 8);
      default: value = $urandom_range(0, 65535);
    endcase
    value[31:16] = 16'($urandom());
    write_reg(CFG_ROWS, value);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run_len;
    logic [31:0] p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_8000, 32'h0000_0000, 1'b0);
    send_word(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0001_0001, 1'b1);
    send_word(32'h1234_5678, 32'h1234_5678, 1'b1);
    drain_results();
    write_reg(CFG_DELTA, 32'h0000_0000);
    write_reg(CFG_MODE, {30'b0, RED_SUM});
    write_reg(CFG_ROWS, 32'h0000_0000);
    send_word(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    drain_results();
    write_reg(CFG_DELTA, 32'h0001_0000);
    write_reg(CFG_MODE, {30'b0, RED_SUM_ALIAS});
    send_word(32'h0003_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0002_0000, 1'b1);
    drain_results();
    write_reg(CFG_MODE, {30'b0, RED_ROWS});
    send_word(32'h0005_0000, 32'h0000_0000, 1'b1);
    drain_results();
    write_reg(CFG_DELTA, 32'hFFFF_FFFF);
    write_reg(CFG_MODE, {30'b0, RED_SUM});
    send_word(32'h3FFF_FFFF, 32'hC000_0000, 1'b1);
    drain_results();
    write_reg(CFG_ROWS, 32'h0000_FFFF);
    write_reg(CFG_MODE, {30'b0, RED_ROWS});
    send_word(32'h7FFF_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);

    sent = 0;
    while (sent < RandomWords) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        rand_config();
      end
      calm = (sent >= 150 && sent < 250);
      run_len = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned k = 0; k < run_len; k++) begin
        if ($urandom_range(49) == 0) drain_results();
        p = rand_value();
        send_word(p, rand_target(p), k == run_len - 1);
        sent++;
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
